// ===== rtl/spm_pkg.sv =====
// Shared types, sizes and helpers for the sparse polynomial multiplier.
// No dependencies; used by every other file in rtl/.
package spm_pkg;

    localparam int MAX_FIRST_TERMS   = 8;
    localparam int MAX_SECOND_TERMS  = 8;
    localparam int MAX_PRODUCT_TERMS = 64;

    localparam int COEF_W  = 16;
    localparam int EXPO_W  = 16;
    localparam int PCOEF_W = 32;
    localparam int PEXPO_W = 17;

    localparam int FIRST_IDX_W  = (MAX_FIRST_TERMS > 1) ? $clog2(MAX_FIRST_TERMS) : 1;
    localparam int SECOND_IDX_W = (MAX_SECOND_TERMS > 1) ? $clog2(MAX_SECOND_TERMS) : 1;
    localparam int FIRST_CNT_W  = $clog2(MAX_FIRST_TERMS + 1);
    localparam int SECOND_CNT_W = $clog2(MAX_SECOND_TERMS + 1);
    localparam int TMR_W        = $clog2(MAX_PRODUCT_TERMS + 3);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MULT,
        ST_DRAIN,
        ST_SORT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_ACC,
        MODE_SORT,
        MODE_SHIFT
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  parity;
        logic  emit;
        logic  loading;
    } chain_ctl_t;

    typedef struct packed {
        logic                odd;
        logic                first;
    } cell_pos_t;

    typedef struct packed {
        logic               valid;
        logic [PEXPO_W-1:0] expo;
        logic [PCOEF_W-1:0] coef;
    } entry_t;

    // true when the lower entry of a pair belongs above the upper one
    function automatic logic spm_swap(input entry_t upper, input entry_t lower);
        spm_swap = lower.valid && (!upper.valid || (lower.expo > upper.expo));
    endfunction

endpackage

// ===== rtl/spm_cell.sv =====
// One product table cell: holds one merged term, merges or forwards products,
// takes part in the odd-even sort and the output shift. Depends on spm_pkg.
module spm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spm_pkg::chain_ctl_t ctl,
    input  spm_pkg::cell_pos_t pos,
    input  spm_pkg::entry_t    upper_entry,
    input  spm_pkg::entry_t    lower_entry,
    input  spm_pkg::entry_t    pass_in,
    output spm_pkg::entry_t    pass_out,
    output spm_pkg::entry_t    entry_out
);

    spm_pkg::entry_t ent_reg;
    spm_pkg::entry_t ent_next;
    spm_pkg::entry_t pass_reg;
    spm_pkg::entry_t pass_next;

    always_comb
    begin
        ent_next  = ent_reg;
        pass_next = pass_in;
        pass_next.valid = 1'b0;
        case (ctl.mode)
            spm_pkg::MODE_ACC:
            begin
                if (pass_in.valid)
                begin
                    if (ent_reg.valid && (ent_reg.expo == pass_in.expo))
                    begin
                        ent_next.coef = ent_reg.coef + pass_in.coef;
                    end
                    else if (!ent_reg.valid)
                    begin
                        ent_next = pass_in;
                    end
                    else
                    begin
                        pass_next = pass_in;
                    end
                end
            end
            spm_pkg::MODE_SORT:
            begin
                if (pos.odd == ctl.parity)
                begin
                    if (spm_pkg::spm_swap(ent_reg, lower_entry))
                    begin
                        ent_next = lower_entry;
                    end
                end
                else if (!pos.first && spm_pkg::spm_swap(upper_entry, ent_reg))
                begin
                    ent_next = upper_entry;
                end
            end
            spm_pkg::MODE_SHIFT:
            begin
                ent_next = lower_entry;
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg  <= '0;
            pass_reg <= '0;
        end
        else
        begin
            ent_reg  <= ent_next;
            pass_reg <= pass_next;
        end
    end

    assign pass_out  = pass_reg;
    assign entry_out = ent_reg;

endmodule

// ===== rtl/spm_ctrl.sv =====
// Term stores, pair sequencer, coefficient multiplier and phase control.
// Depends on spm_pkg.
module spm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic signed [spm_pkg::COEF_W-1:0] coefficient,
    input  logic [spm_pkg::EXPO_W-1:0]    exponent,
    input  logic                          last_term,
    input  logic                          head_valid,
    input  logic                          out_take,
    output spm_pkg::chain_ctl_t           ctl,
    output spm_pkg::entry_t               product
);

    logic signed [spm_pkg::COEF_W-1:0] f_coef_mem [spm_pkg::MAX_FIRST_TERMS];
    logic [spm_pkg::EXPO_W-1:0]        f_expo_mem [spm_pkg::MAX_FIRST_TERMS];
    logic signed [spm_pkg::COEF_W-1:0] s_coef_mem [spm_pkg::MAX_SECOND_TERMS];
    logic [spm_pkg::EXPO_W-1:0]        s_expo_mem [spm_pkg::MAX_SECOND_TERMS];

    spm_pkg::state_t                 state_reg, state_next;
    logic [spm_pkg::FIRST_CNT_W-1:0] f_cnt_reg, f_cnt_next;
    logic [spm_pkg::SECOND_CNT_W-1:0] s_cnt_reg, s_cnt_next;
    logic [spm_pkg::FIRST_IDX_W-1:0] i_reg, i_next;
    logic [spm_pkg::SECOND_IDX_W-1:0] j_reg, j_next;
    logic [spm_pkg::TMR_W-1:0]       tmr_reg, tmr_next;
    logic                            f_wr, s_wr, issue;
    logic                            i_last, j_last;
    spm_pkg::entry_t                 prod_reg;

    assign i_last = (spm_pkg::FIRST_CNT_W'(i_reg) == f_cnt_reg - spm_pkg::FIRST_CNT_W'(1));
    assign j_last = (spm_pkg::SECOND_CNT_W'(j_reg) == s_cnt_reg - spm_pkg::SECOND_CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        f_cnt_next = f_cnt_reg;
        s_cnt_next = s_cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        tmr_next   = tmr_reg;
        f_wr       = 1'b0;
        s_wr       = 1'b0;
        issue      = 1'b0;
        in_stall   = 1'b1;
        ctl.mode    = spm_pkg::MODE_HOLD;
        ctl.parity  = tmr_reg[0];
        ctl.emit    = 1'b0;
        ctl.loading = 1'b0;
        case (state_reg)
            spm_pkg::ST_LOAD:
            begin
                in_stall    = 1'b0;
                ctl.loading = 1'b1;
                if (in_valid)
                begin
                    if (!command)
                    begin
                        if (f_cnt_reg < spm_pkg::FIRST_CNT_W'(spm_pkg::MAX_FIRST_TERMS))
                        begin
                            f_wr       = 1'b1;
                            f_cnt_next = f_cnt_reg + spm_pkg::FIRST_CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (s_cnt_reg < spm_pkg::SECOND_CNT_W'(spm_pkg::MAX_SECOND_TERMS))
                        begin
                            s_wr       = 1'b1;
                            s_cnt_next = s_cnt_reg + spm_pkg::SECOND_CNT_W'(1);
                        end
                        if (last_term)
                        begin
                            state_next = spm_pkg::ST_MULT;
                            i_next     = '0;
                            j_next     = '0;
                        end
                    end
                end
            end
            spm_pkg::ST_MULT:
            begin
                ctl.mode = spm_pkg::MODE_ACC;
                tmr_next = '0;
                if ((f_cnt_reg == '0) || (s_cnt_reg == '0))
                begin
                    state_next = spm_pkg::ST_DRAIN;
                end
                else
                begin
                    issue = 1'b1;
                    if (j_last)
                    begin
                        j_next = '0;
                        i_next = i_reg + spm_pkg::FIRST_IDX_W'(1);
                        if (i_last)
                        begin
                            state_next = spm_pkg::ST_DRAIN;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + spm_pkg::SECOND_IDX_W'(1);
                    end
                end
            end
            spm_pkg::ST_DRAIN:
            begin
                ctl.mode = spm_pkg::MODE_ACC;
                tmr_next = tmr_reg + spm_pkg::TMR_W'(1);
                if (tmr_reg == spm_pkg::TMR_W'(spm_pkg::MAX_PRODUCT_TERMS + 1))
                begin
                    state_next = spm_pkg::ST_SORT;
                    tmr_next   = '0;
                end
            end
            spm_pkg::ST_SORT:
            begin
                ctl.mode = spm_pkg::MODE_SORT;
                tmr_next = tmr_reg + spm_pkg::TMR_W'(1);
                if (tmr_reg == spm_pkg::TMR_W'(spm_pkg::MAX_PRODUCT_TERMS - 1))
                begin
                    state_next = spm_pkg::ST_EMIT;
                end
            end
            spm_pkg::ST_EMIT:
            begin
                ctl.emit = 1'b1;
                ctl.mode = out_take ? spm_pkg::MODE_SHIFT : spm_pkg::MODE_HOLD;
                if (!head_valid)
                begin
                    state_next = spm_pkg::ST_LOAD;
                    f_cnt_next = '0;
                    s_cnt_next = '0;
                end
            end
            default:
            begin
                state_next = spm_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spm_pkg::ST_LOAD;
            f_cnt_reg <= '0;
            s_cnt_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            tmr_reg   <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            f_cnt_reg      <= f_cnt_next;
            s_cnt_reg      <= s_cnt_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            tmr_reg        <= tmr_next;
            prod_reg.valid <= issue;
            prod_reg.coef  <= spm_pkg::PCOEF_W'(s_coef_mem[j_reg])
                            * spm_pkg::PCOEF_W'(f_coef_mem[i_reg]);
            prod_reg.expo  <= spm_pkg::PEXPO_W'(f_expo_mem[i_reg])
                            + spm_pkg::PEXPO_W'(s_expo_mem[j_reg]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_wr)
        begin
            f_coef_mem[f_cnt_reg[spm_pkg::FIRST_IDX_W-1:0]] <= coefficient;
            f_expo_mem[f_cnt_reg[spm_pkg::FIRST_IDX_W-1:0]] <= exponent;
        end
        if (s_wr)
        begin
            s_coef_mem[s_cnt_reg[spm_pkg::SECOND_IDX_W-1:0]] <= coefficient;
            s_expo_mem[s_cnt_reg[spm_pkg::SECOND_IDX_W-1:0]] <= exponent;
        end
    end

    assign product = prod_reg;

endmodule

// ===== rtl/sparse_polynomial_multiplier.sv =====
// Sparse polynomial multiplier top level: controller plus a chain of table cells.
// Depends on spm_pkg, spm_ctrl and spm_cell.
//
// Term words load one per cycle. The word of the second polynomial marked
// last_term starts the multiply and the input stalls until every result is
// out: the term pairs are issued through the multiplier into the cell chain
// (one pair per cycle; none when either list is empty), the last product
// then ripples down the chain, odd-even passes order the cells by exponent,
// then one result word per cycle leaves the head cell while the receiver
// does not stall, highest exponent first, and the block returns to loading.
// Merging and ordering are bounded by the chain length, one cell per table
// entry.
module sparse_polynomial_multiplier (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic signed [spm_pkg::COEF_W-1:0] coefficient,
    input  logic [spm_pkg::EXPO_W-1:0]        exponent,
    input  logic                              last_term,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [spm_pkg::PCOEF_W-1:0] product_coefficient,
    output logic [spm_pkg::PEXPO_W-1:0]       product_exponent,
    output logic                              last_result
);

    spm_pkg::chain_ctl_t ctl;
    spm_pkg::entry_t     ent  [spm_pkg::MAX_PRODUCT_TERMS+1];
    spm_pkg::entry_t     pass [spm_pkg::MAX_PRODUCT_TERMS+1];
    logic [spm_pkg::MAX_PRODUCT_TERMS-1:0] pass_busy;
    logic                out_take;

    assign out_valid = ctl.emit && ent[0].valid;
    assign out_take  = out_valid && !out_stall;

    spm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .coefficient (coefficient),
        .exponent    (exponent),
        .last_term   (last_term),
        .head_valid  (ent[0].valid),
        .out_take    (out_take),
        .ctl         (ctl),
        .product     (pass[0])
    );

    assign ent[spm_pkg::MAX_PRODUCT_TERMS] = '0;

    for (genvar k = 0; k < spm_pkg::MAX_PRODUCT_TERMS; k++)
    begin : g_cell
        spm_pkg::entry_t   upper;
        spm_pkg::cell_pos_t pos;

        if (k == 0)
        begin : g_head
            assign upper = '0;
        end
        else
        begin : g_body
            assign upper = ent[k-1];
        end

        assign pos.odd   = 1'(k % 2);
        assign pos.first = (k == 0);
        assign pass_busy[k] = pass[k+1].valid;

        spm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .pos         (pos),
            .upper_entry (upper),
            .lower_entry (ent[k+1]),
            .pass_in     (pass[k]),
            .pass_out    (pass[k+1]),
            .entry_out   (ent[k])
        );
    end

    assign product_coefficient = ent[0].coef;
    assign product_exponent    = ent[0].expo;
    assign last_result         = !ent[1].valid;

    a_last_ends : assert property (@(posedge clk) disable iff (!rst_n)
        out_take && last_result |=> !out_valid)
        else $error("word after last result");

    a_descending : assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !last_result |=> out_valid && (product_exponent < $past(product_exponent)))
        else $error("results not in descending exponent order");

    a_load_empty : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.loading |-> !ent[0].valid)
        else $error("table not empty while loading");

    a_drained : assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.mode == spm_pkg::MODE_SORT) |-> (pass_busy == '0))
        else $error("product still in flight at sort");

endmodule

// ===== verif/tb_sparse_polynomial_multiplier.sv =====
// Testbench for sparse_polynomial_multiplier: directed stimulus table, then random polynomial pairs.
// Every result word is checked against the directed table's expected term or an in-bench polynomial product predictor.
// Depends on spm_pkg and the sparse_polynomial_multiplier RTL only.
`timescale 1ns / 1ps

module tb_sparse_polynomial_multiplier;

    localparam logic CMD_FIRST  = 1'b0;
    localparam logic CMD_SECOND = 1'b1;

    localparam logic [1:0] ROW_PREDICT = 2'd0;
    localparam logic [1:0] ROW_NONE    = 2'd1;
    localparam logic [1:0] ROW_ONE     = 2'd2;

    localparam int RANDOM_WORDS = 350;
    localparam int QUIET_FROM   = 300;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 300;

    typedef struct packed {
        logic                                  command;
        logic signed [spm_pkg::COEF_W-1:0]     coef;
        logic [spm_pkg::EXPO_W-1:0]            expo;
        logic                                  last;
    } term_word_t;

    typedef struct packed {
        logic signed [spm_pkg::PCOEF_W-1:0]    coef;
        logic [spm_pkg::PEXPO_W-1:0]           expo;
        logic                                  last;
    } product_term_t;

    typedef struct packed {
        term_word_t                            w;
        logic [1:0]                            kind;
        logic signed [spm_pkg::PCOEF_W-1:0]    coef;
        logic [spm_pkg::PEXPO_W-1:0]           expo;
    } stim_row_t;

    localparam int WORD_BITS = $bits(term_word_t);

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    logic                                  command = CMD_FIRST;
    logic signed [spm_pkg::COEF_W-1:0]     coefficient = '0;
    logic [spm_pkg::EXPO_W-1:0]            exponent = '0;
    logic                                  last_term = 1'b0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic signed [spm_pkg::PCOEF_W-1:0]    product_coefficient;
    logic [spm_pkg::PEXPO_W-1:0]           product_exponent;
    logic                                  last_result;

    // predictor state
    term_word_t    first_poly [spm_pkg::MAX_FIRST_TERMS];
    term_word_t    second_poly [spm_pkg::MAX_SECOND_TERMS];
    int            first_count = 0;
    int            second_count = 0;
    product_term_t product_table [spm_pkg::MAX_PRODUCT_TERMS];
    product_term_t fresh_terms [$];
    product_term_t pending_terms [$];

    stim_row_t     stim_rows [$];
    int            errors = 0;
    int            words_sent = 0;
    int            gap_odds = 4;
    bit            quiet = 1'b0;
    bit            hold_req = 1'b0;

    sparse_polynomial_multiplier u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .command             (command),
        .coefficient         (coefficient),
        .exponent            (exponent),
        .last_term           (last_term),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .product_coefficient (product_coefficient),
        .product_exponent    (product_exponent),
        .last_result         (last_result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[sparse_polynomial_multiplier] ERROR");
        $finish;
    end

    // loads one word; on the closing word of the second polynomial forms the product terms
    task automatic poly_product(input term_word_t w);
        int            i;
        int            j;
        int            k;
        int            n;
        int            a;
        int            b;
        bit            merged;
        logic [spm_pkg::PEXPO_W-1:0] e;
        product_term_t t;
        fresh_terms.delete();
        if (w.command == CMD_FIRST)
        begin
            if (first_count < spm_pkg::MAX_FIRST_TERMS)
            begin
                first_poly[first_count] = w;
                first_count++;
            end
            return;
        end
        if (second_count < spm_pkg::MAX_SECOND_TERMS)
        begin
            second_poly[second_count] = w;
            second_count++;
        end
        if (!w.last)
            return;
        n = 0;
        for (i = 0; i < first_count; i++)
        begin
            for (j = 0; j < second_count; j++)
            begin
                a = int'(first_poly[i].coef);
                b = int'(second_poly[j].coef);
                e = {1'b0, first_poly[i].expo} + {1'b0, second_poly[j].expo};
                merged = 1'b0;
                for (k = 0; k < n; k++)
                begin
                    if (!merged && product_table[k].expo == e)
                    begin
                        product_table[k].coef = product_table[k].coef + a * b;
                        merged = 1'b1;
                    end
                end
                if (!merged && n < spm_pkg::MAX_PRODUCT_TERMS)
                begin
                    product_table[n].coef = a * b;
                    product_table[n].expo = e;
                    n++;
                end
            end
        end
        // highest exponent first
        for (i = 1; i < n; i++)
        begin
            t = product_table[i];
            j = i;
            while (j > 0 && product_table[j-1].expo < t.expo)
            begin
                product_table[j] = product_table[j-1];
                j--;
            end
            product_table[j] = t;
        end
        for (i = 0; i < n; i++)
        begin
            t = product_table[i];
            t.last = (i == n - 1);
            fresh_terms.push_back(t);
        end
        first_count = 0;
        second_count = 0;
    endtask

    // offers one word until taken, then books what it should produce
    task automatic offer_word(input term_word_t w, input logic [1:0] kind,
                              input logic signed [31:0] ecoef, input logic [16:0] eexpo);
        product_term_t t;
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= w.command;
        coefficient <= w.coef;
        exponent    <= w.expo;
        last_term   <= w.last;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        poly_product(w);
        if (kind == ROW_PREDICT)
        begin
            foreach (fresh_terms[i])
                pending_terms.push_back(fresh_terms[i]);
        end
        else if (kind == ROW_ONE)
        begin
            t.coef = ecoef;
            t.expo = eexpo;
            t.last = 1'b1;
            pending_terms.push_back(t);
        end
    endtask

    task automatic add_row(input logic cmd, input int c, input int e, input logic last,
                           input logic [1:0] kind, input int ecoef, input int eexpo);
        stim_row_t r;
        r.w.command = cmd;
        r.w.coef    = spm_pkg::COEF_W'(c);
        r.w.expo    = spm_pkg::EXPO_W'(e);
        r.w.last    = last;
        r.kind      = kind;
        r.coef      = ecoef;
        r.expo      = spm_pkg::PEXPO_W'(eexpo);
        stim_rows.push_back(r);
    endtask

    function automatic term_word_t rand_term(input logic cmd, input logic last,
                                             input int emode, input int cmode);
        term_word_t w;
        w.command = cmd;
        w.last    = last;
        case (emode)
            0: w.expo = spm_pkg::EXPO_W'($urandom_range(0, 7));
            1: w.expo = 16'hFFFF - spm_pkg::EXPO_W'($urandom_range(0, 7));
            default: w.expo = spm_pkg::EXPO_W'($urandom_range(0, 65535));
        endcase
        case (cmode)
            0:
            begin
                case ($urandom_range(0, 4))
                    0: w.coef = 16'sh8000;
                    1: w.coef = 16'sd32767;
                    2: w.coef = -16'sd1;
                    3: w.coef = 16'sd0;
                    default: w.coef = 16'sd1;
                endcase
            end
            1: w.coef = spm_pkg::COEF_W'(int'($urandom_range(0, 20)) - 10);
            default: w.coef = spm_pkg::COEF_W'($urandom_range(0, 65535));
        endcase
        return w;
    endfunction

    // one polynomial pair, mostly well formed, sometimes with stray or overflowing words
    task automatic send_poly_pair();
        int  nf;
        int  ns;
        int  emode;
        int  cmode;
        int  i;
        bit  second_early;
        term_word_t w;
        emode = $urandom_range(0, 2);
        cmode = $urandom_range(0, 2);
        nf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 8);
        ns = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
        second_early = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                w = WORD_BITS'({$urandom, $urandom});
                offer_word(w, ROW_PREDICT, '0, '0);
            end
        end
        if (second_early)
            for (i = 0; i < ns - 1; i++)
                offer_word(rand_term(CMD_SECOND, 1'b0, emode, cmode), ROW_PREDICT, '0, '0);
        for (i = 0; i < nf; i++)
            offer_word(rand_term(CMD_FIRST, $urandom_range(0, 7) == 0, emode, cmode),
                       ROW_PREDICT, '0, '0);
        if (!second_early)
            for (i = 0; i < ns - 1; i++)
                offer_word(rand_term(CMD_SECOND, 1'b0, emode, cmode), ROW_PREDICT, '0, '0);
        offer_word(rand_term(CMD_SECOND, 1'b1, emode, cmode), ROW_PREDICT, '0, '0);
    endtask

    task automatic wait_for_results();
        do
            @(posedge clk);
        while (pending_terms.size() != 0);
    endtask

    // receiver: random stall bursts, one long hold on request, none at the end
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        product_term_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_terms.size() == 0)
            begin
                $error("unexpected result word: coef %0d expo %0d",
                       product_coefficient, product_exponent);
                errors++;
            end
            else
            begin
                want = pending_terms.pop_front();
                if (product_coefficient !== want.coef)
                begin
                    $error("product_coefficient: expected %0d, got %0d",
                           want.coef, product_coefficient);
                    errors++;
                end
                if (product_exponent !== want.expo)
                begin
                    $error("product_exponent: expected %0d, got %0d",
                           want.expo, product_exponent);
                    errors++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result: expected %0d, got %0d", want.last, last_result);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int i;
        int seq;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty first polynomial: multiply gives nothing
        add_row(CMD_SECOND, 100, 5, 1'b1, ROW_NONE, 0, 0);
        // extreme single terms
        add_row(CMD_FIRST, 32767, 65535, 1'b0, ROW_NONE, 0, 0);
        add_row(CMD_SECOND, -32768, 65535, 1'b1, ROW_ONE, -1073709056, 131070);
        add_row(CMD_FIRST, -32768, 0, 1'b0, ROW_NONE, 0, 0);
        add_row(CMD_SECOND, -32768, 0, 1'b1, ROW_ONE, 1073741824, 0);
        // last_term on a first-polynomial word is ignored; merge cancels to zero
        add_row(CMD_FIRST, 3, 1, 1'b1, ROW_NONE, 0, 0);
        add_row(CMD_FIRST, -3, 1, 1'b0, ROW_NONE, 0, 0);
        add_row(CMD_SECOND, 1, 0, 1'b1, ROW_ONE, 0, 1);
        // both lists overflow; dropped closing word still starts the multiply
        for (i = 0; i < 9; i++)
            add_row(CMD_FIRST, (i % 2) ? 32767 : -32768, 65535 - i, 1'b0, ROW_NONE, 0, 0);
        for (i = 0; i < 9; i++)
            add_row(CMD_SECOND, (i % 2) ? -32768 : 32767, 65535 - 8 * i, i == 8,
                    (i == 8) ? ROW_PREDICT : ROW_NONE, 0, 0);

        foreach (stim_rows[r])
            offer_word(stim_rows[r].w, stim_rows[r].kind, stim_rows[r].coef, stim_rows[r].expo);
        in_valid <= 1'b0;
        wait_for_results();

        words_sent = 0;
        seq = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            if (words_sent >= QUIET_FROM)
                quiet = 1'b1;
            gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
            if (seq == 3)
                hold_req = 1'b1;
            send_poly_pair();
            if (seq % 9 == 5)
            begin
                in_valid <= 1'b0;
                wait_for_results();
            end
            seq++;
        end
        in_valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE) @(posedge clk);

        if (errors == 0)
            $display("[sparse_polynomial_multiplier] OK");
        else
            $display("[sparse_polynomial_multiplier] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/spm_pkg.sv
rtl/spm_cell.sv
rtl/spm_ctrl.sv
rtl/sparse_polynomial_multiplier.sv
verif/tb_sparse_polynomial_multiplier.sv
